// File: rtl/bmpd_pkg.sv
// Shared types and codes for the BMP pixel stream decoder.
// No dependencies; used by bmpd_palette and bmp_pixel_stream_decoder.
package bmpd_pkg;

  localparam int CFG_DATA_W = 13;

  localparam logic [1:0] MODE_1BPP  = 2'd0;
  localparam logic [1:0] MODE_4BPP  = 2'd1;
  localparam logic [1:0] MODE_8BPP  = 2'd2;
  localparam logic [1:0] MODE_24BPP = 2'd3;

  localparam logic [1:0] REG_PIXEL_MODE      = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_PALETTE_ENTRIES = 2'd3;

  typedef struct packed {
    logic        rd_en;
    logic [7:0]  rd_idx;
    logic        wr_en;
    logic [8:0]  wr_idx;
    logic [23:0] wr_rgb;
  } pal_req_t;

endpackage

// File: rtl/bmpd_palette.sv
// Palette store: synchronous RAM with a registered read and per-entry valid bits.
// Depends on bmpd_pkg (pal_req_t). Out-of-range or never-written entries read as zero.
module bmpd_palette #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  bmpd_pkg::pal_req_t req,
  output logic [23:0]        rgb
);

  localparam int AW = $clog2(DEPTH);

  logic [23:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [23:0]      rd_data;
  logic             rd_hit;
  logic [AW-1:0]    ra;
  logic [AW-1:0]    wa;
  logic             rd_in_range;
  logic             wr_ok;

  assign ra          = req.rd_idx[AW-1:0];
  assign wa          = req.wr_idx[AW-1:0];
  assign rd_in_range = {1'b0, req.rd_idx} < 9'(DEPTH);
  assign wr_ok       = req.wr_en && (req.wr_idx < 9'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wa] <= req.wr_rgb;
    end
    if (req.rd_en) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_ok) begin
        valid[wa] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= rd_in_range && valid[ra];
      end
    end
  end

  assign rgb = rd_hit ? rd_data : 24'd0;

endmodule

// File: rtl/bmp_pixel_stream_decoder.sv
// BMP pixel stream decoder, top level: byte sequencer, row counters and output pipeline.
// Depends on bmpd_pkg and bmpd_palette.
//
// Input channel: one file byte per item (data_byte, byte_valid, byte_stall).
// The first palette_entries*4 bytes load the palette (blue, green, red, unused);
// all later bytes are pixel rows at the configured depth, with row padding
// to a multiple of four bytes consumed silently.
// Output channel: one decoded pixel per item (pixel_valid, pixel_stall) with its
// column, stored row, a last_of_byte flag and an image_done flag.
// Path: an accepted byte goes from the hold stage through the palette RAM read
// to the output register, where its pixel is presented.
// Throughput: one pixel per cycle at 1, 4 and 8 bpp unless the receiver stalls, set by
// the single palette read port; at 24 bpp three bytes make one pixel. At 8 and 24 bpp a
// byte is taken every cycle; at 4 and 1 bpp a byte holds the input until it has given its
// last pixel. Palette and padding bytes give no pixel and leave as the pipeline advances.
// The receiver stalling freezes the whole pipeline; byte_stall rises with it while a byte is held.
// Reset clears the counters, the palette valid bits and the config registers
// to their defaults (8 bpp, 1x1 image, no palette); no clearing pass is needed.
// The user must write config via cfg_write/cfg_index/cfg_data only while the block is idle; no check enforces it.
module bmp_pixel_stream_decoder #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [bmpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  logic [7:0]                      data_byte,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic [11:0]                     pixel_x,
  output logic [11:0]                     pixel_y,
  output logic                            last_of_byte,
  output logic                            image_done
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int JW = WW + 2;
  localparam int XW = JW + 3;

  // config registers
  logic [1:0]  pixel_mode;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [8:0]  palette_entries;

  // decoder state
  logic          in_pixel_phase;
  logic [8:0]    palette_index;
  logic [1:0]    quad_byte_count;
  logic [15:0]   partial_colour;
  logic [JW-1:0] row_byte_count;
  logic [JW-1:0] row_div3;
  logic [1:0]    row_mod3;
  logic [HW-1:0] row_count;
  logic [1:0]    channel_count;

  // hold stage
  logic       a_valid;
  logic [7:0] a_byte;
  logic [2:0] k;

  // read stage
  logic        b_valid;
  logic        b_use_pal;
  logic [23:0] b_rgb;
  logic [11:0] b_x;
  logic [11:0] b_y;
  logic        b_last;
  logic        b_done;

  logic advance;
  logic a_fire;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [JW-1:0] wj;
  logic [JW-1:0] used;
  logic [JW-1:0] padded;
  logic          phase;
  logic          in_row;
  logic [2:0]    last_k;
  logic [XW-1:0] x_per;
  logic [XW-1:0] x_sel;
  logic [7:0]    idx;
  logic          emit;
  logic          pix_last;
  logic          byte_end;
  logic          done;
  logic [JW-1:0] j_next;
  logic [HW:0]   rc_inc;

  bmpd_pkg::pal_req_t pal_req;
  logic [23:0]        pal_rgb;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode      <= bmpd_pkg::MODE_8BPP;
      image_width     <= 13'd1;
      image_height    <= 13'd1;
      palette_entries <= 9'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmpd_pkg::REG_PIXEL_MODE:      pixel_mode      <= cfg_data[1:0];
        bmpd_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg_data[12:0];
        bmpd_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg_data[12:0];
        bmpd_pkg::REG_PALETTE_ENTRIES: palette_entries <= cfg_data[8:0];
      endcase
    end
  end

  // clamped dimensions and row geometry
  always_comb begin
    if (image_width == 13'd0) begin
      w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == 13'd0) begin
      h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
    wj = JW'(w);
    unique case (pixel_mode)
      bmpd_pkg::MODE_1BPP: begin
        used   = (wj + JW'(7)) >> 3;
        last_k = 3'd7;
        x_per  = (XW'(row_byte_count) << 3) + XW'(k);
        idx    = {7'd0, a_byte[3'd7 - k]};
      end
      bmpd_pkg::MODE_4BPP: begin
        used   = (wj + JW'(1)) >> 1;
        last_k = 3'd1;
        x_per  = (XW'(row_byte_count) << 1) + XW'(k);
        idx    = k[0] ? {4'd0, a_byte[3:0]} : {4'd0, a_byte[7:4]};
      end
      bmpd_pkg::MODE_8BPP: begin
        used   = wj;
        last_k = 3'd0;
        x_per  = XW'(row_byte_count);
        idx    = a_byte;
      end
      default: begin
        used   = (wj << 1) + wj;
        last_k = 3'd0;
        x_per  = XW'(row_byte_count);
        idx    = a_byte;
      end
    endcase
    padded = (used + JW'(3)) & ~JW'(3);
  end

  // per-cycle step of the byte in the hold stage
  always_comb begin
    phase    = in_pixel_phase || (palette_index >= palette_entries);
    in_row   = row_byte_count < used;
    emit     = 1'b0;
    pix_last = 1'b1;
    x_sel    = x_per;
    if (phase && in_row) begin
      if (pixel_mode == bmpd_pkg::MODE_24BPP) begin
        x_sel = XW'(row_div3);
        emit  = channel_count == 2'd2;
      end else begin
        emit     = 1'b1;
        pix_last = (k == last_k) || (x_per == XW'(w - WW'(1)));
      end
    end
    byte_end = pix_last;
    done     = (x_sel == XW'(w - WW'(1))) && (row_count == h - HW'(1));
  end

  assign advance    = !pixel_valid || !pixel_stall;
  assign a_fire     = a_valid && advance;
  assign byte_stall = a_valid && !(advance && byte_end);
  assign j_next     = row_byte_count + JW'(1);
  assign rc_inc     = (HW + 1)'(row_count) + (HW + 1)'(1);

  always_comb begin
    pal_req.rd_en  = a_fire && emit && (pixel_mode != bmpd_pkg::MODE_24BPP);
    pal_req.rd_idx = idx;
    pal_req.wr_en  = a_fire && !phase && (quad_byte_count == 2'd2);
    pal_req.wr_idx = palette_index;
    pal_req.wr_rgb = {a_byte, partial_colour};
  end

  bmpd_palette #(
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk(clk),
    .rst(rst),
    .req(pal_req),
    .rgb(pal_rgb)
  );

  // hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      k       <= 3'd0;
    end else begin
      if (!byte_stall) begin
        a_valid <= byte_valid;
      end
      if (a_fire) begin
        k <= byte_end ? 3'd0 : k + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      a_byte <= data_byte;
    end
  end

  // decoder state, updated as a byte completes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pixel_phase  <= 1'b0;
      palette_index   <= 9'd0;
      quad_byte_count <= 2'd0;
      partial_colour  <= 16'd0;
      row_byte_count  <= '0;
      row_div3        <= '0;
      row_mod3        <= 2'd0;
      row_count       <= '0;
      channel_count   <= 2'd0;
    end else if (a_fire && byte_end) begin
      if (!phase) begin
        case (quad_byte_count)
          2'd0:    partial_colour       <= {8'd0, a_byte};
          2'd1:    partial_colour[15:8] <= a_byte;
          2'd3:    palette_index        <= palette_index + 9'd1;
          default: ;
        endcase
        quad_byte_count <= quad_byte_count + 2'd1;
      end else begin
        in_pixel_phase <= 1'b1;
        if (in_row && pixel_mode == bmpd_pkg::MODE_24BPP) begin
          case (channel_count)
            2'd0: begin
              partial_colour <= {8'd0, a_byte};
              channel_count  <= 2'd1;
            end
            2'd1: begin
              partial_colour[15:8] <= a_byte;
              channel_count        <= 2'd2;
            end
            default: channel_count <= 2'd0;
          endcase
        end
        if (j_next >= padded) begin
          row_byte_count <= '0;
          row_div3       <= '0;
          row_mod3       <= 2'd0;
          channel_count  <= 2'd0;
          row_count      <= (rc_inc >= (HW + 1)'(h)) ? '0 : HW'(rc_inc);
        end else begin
          row_byte_count <= j_next;
          if (row_mod3 == 2'd2) begin
            row_mod3 <= 2'd0;
            row_div3 <= row_div3 + JW'(1);
          end else begin
            row_mod3 <= row_mod3 + 2'd1;
          end
        end
      end
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      pixel_valid <= 1'b0;
    end else if (advance) begin
      b_valid     <= a_fire && emit;
      pixel_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (a_fire && emit) begin
        b_use_pal <= pixel_mode != bmpd_pkg::MODE_24BPP;
        b_rgb     <= {a_byte, partial_colour};
        b_x       <= 12'(x_sel);
        b_y       <= 12'(row_count);
        b_last    <= pix_last;
        b_done    <= done;
      end
      if (b_valid) begin
        {red, green, blue} <= b_use_pal ? pal_rgb : b_rgb;
        pixel_x            <= b_x;
        pixel_y            <= b_y;
        last_of_byte       <= b_last;
        image_done         <= b_done;
      end
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pal_req.rd_en && pal_req.wr_en))
    else $error("palette read and write in the same cycle");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && image_done) |-> last_of_byte)
    else $error("image_done without last_of_byte");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (a_valid && pixel_mode != bmpd_pkg::MODE_1BPP) |-> (k <= 3'd1))
    else $error("sub-pixel counter out of range");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    (a_valid && advance && !byte_end) |=> (a_valid && $stable(a_byte)))
    else $error("byte left the hold stage before its pixels drained");

endmodule
